// ===== hdl/btl_pkg.sv =====
// Shared types, character codes and keyword table for the BASIC token lexer.
`default_nettype none

package btl_pkg;

  localparam int unsigned PROGRAM_BYTES = 16384;
  localparam int unsigned TOKEN_MAX     = 79;

  localparam int unsigned POS_W   = 14;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned POS_MAX = (2 ** POS_W) - 1;
  localparam int unsigned LEN_MAX = (2 ** LEN_W) - 1;
  localparam int unsigned PREFIX_W = 48;
  localparam int unsigned KW_CHARS = 6;
  localparam int unsigned KW_NUM   = 12;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam logic [3:0] KW_NONE = 4'd0;

  typedef enum logic [3:0] {
    KIND_SYMBOL   = 4'd0,
    KIND_VARIABLE = 4'd1,
    KIND_NUMBER   = 4'd2,
    KIND_KEYWORD  = 4'd3,
    KIND_STRING   = 4'd4,
    KIND_EOL      = 4'd5,
    KIND_END      = 4'd6,
    KIND_INVALID  = 4'd7,
    KIND_UNTERM   = 4'd8
  } btl_kind_e;

  typedef enum logic [5:0] {
    MODE_IDLE   = 6'b000001,
    MODE_NUMBER = 6'b000010,
    MODE_WORD   = 6'b000100,
    MODE_STRING = 6'b001000,
    MODE_CR     = 6'b010000,
    MODE_DONE   = 6'b100000
  } btl_mode_e;

  typedef struct packed {
    btl_kind_e          kind;
    logic [3:0]         kw;
    logic [POS_W-1:0]   start;
    logic [LEN_W-1:0]   len;
    logic [7:0]         fc;
    logic               last;
  } btl_result_t;

  // up to two results produced by one byte, in order
  typedef struct packed {
    logic [1:0]  n;
    btl_result_t r0;
    btl_result_t r1;
  } btl_push_t;

  // keywords packed big-endian, folded to lower case
  localparam logic [PREFIX_W-1:0] KW_PACK [KW_NUM] = '{
    48'h00_70_72_69_6e_74,  // print
    48'h00_69_6e_70_75_74,  // input
    48'h00_00_00_00_69_66,  // if
    48'h00_00_74_68_65_6e,  // then
    48'h00_00_67_6f_74_6f,  // goto
    48'h00_00_00_66_6f_72,  // for
    48'h00_00_6e_65_78_74,  // next
    48'h00_00_00_00_74_6f,  // to
    48'h00_67_6f_73_75_62,  // gosub
    48'h72_65_74_75_72_6e,  // return
    48'h00_00_00_65_6e_64,  // end
    48'h00_00_00_72_65_6d   // rem
  };

  localparam logic [LEN_W-1:0] KW_LEN [KW_NUM] = '{
    7'd5, 7'd5, 7'd2, 7'd4, 7'd4, 7'd3, 7'd4, 7'd2, 7'd5, 7'd6, 7'd3, 7'd3
  };

  function automatic logic [3:0] kw_lookup(logic [PREFIX_W-1:0] prefix,
                                           logic [LEN_W-1:0] count);
    logic [3:0] code;
    code = KW_NONE;
    for (int k = 0; k < KW_NUM; k++) begin
      if (count == KW_LEN[k] && prefix == KW_PACK[k]) begin
        code = 4'(k + 1);
      end
    end
    return code;
  endfunction

  function automatic logic is_op(logic [7:0] b);
    logic hit;
    case (b)
      8'h2b, 8'h2d, 8'h2a, 8'h5e, 8'h2f, 8'h25, 8'h3d,
      8'h3b, 8'h28, 8'h29, 8'h2c, 8'h3e, 8'h3c: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // bytes that close a number or a word
  function automatic logic is_stop(logic [7:0] b);
    logic hit;
    case (b)
      CH_NUL, CH_TAB, CH_LF, CH_CR, CH_SPACE,
      8'h3b, 8'h2c, 8'h2b, 8'h2d, 8'h3c, 8'h3e, 8'h2f,
      8'h2a, 8'h25, 8'h5e, 8'h3d, 8'h28, 8'h29: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/btl_core.sv =====
// Lexer state and per-byte classification; yields up to two token results.
`default_nettype none

module btl_core #(
  parameter int unsigned ProgramBytes = btl_pkg::PROGRAM_BYTES,
  parameter int unsigned TokenMax     = btl_pkg::TOKEN_MAX
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               fire_i,
  input  wire logic [7:0]         byte_i,
  output btl_pkg::btl_push_t      push_o
);
  import btl_pkg::*;

  localparam int unsigned PosLimitInt = (ProgramBytes - 1 < POS_MAX) ? ProgramBytes - 1 : POS_MAX;
  localparam int unsigned LenLimitInt = (TokenMax < LEN_MAX) ? TokenMax : LEN_MAX;
  localparam logic [POS_W-1:0] PosLimit = POS_W'(PosLimitInt);
  localparam logic [LEN_W-1:0] LenLimit = LEN_W'(LenLimitInt);

  btl_mode_e            mode_q, mode_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [POS_W-1:0]     start_q, start_d;
  logic [LEN_W-1:0]     cnt_q, cnt_d;
  logic [7:0]           fc_q, fc_d;
  logic [PREFIX_W-1:0]  prefix_q, prefix_d;

  logic                 p_vld, i_vld, run_idle;
  btl_result_t          p_res, i_res;
  logic [LEN_W-1:0]     cnt_inc;
  logic [7:0]           b, fb;
  logic [3:0]           kw;

  assign b       = byte_i;
  assign cnt_inc = (cnt_q < LenLimit) ? cnt_q + LEN_W'(1) : cnt_q;
  assign fb      = (b >= 8'h41 && b <= 8'h5a) ? (b | CASE_BIT) : b;
  assign kw      = kw_lookup(prefix_q, cnt_q);

  always_comb begin
    mode_d   = mode_q;
    start_d  = start_q;
    cnt_d    = cnt_q;
    fc_d     = fc_q;
    prefix_d = prefix_q;
    p_vld    = 1'b0;
    i_vld    = 1'b0;
    run_idle = 1'b0;
    p_res    = '0;
    i_res    = '0;
    p_res.start = start_q;
    p_res.len   = cnt_q;
    p_res.fc    = fc_q;
    i_res.start = pos_q;
    i_res.len   = LEN_W'(1);
    i_res.fc    = b;

    case (mode_q)
      MODE_NUMBER: begin
        if (is_stop(b)) begin
          p_vld      = 1'b1;
          p_res.kind = KIND_NUMBER;
          run_idle   = 1'b1;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      MODE_WORD: begin
        if (is_stop(b)) begin
          p_vld      = 1'b1;
          p_res.kind = (kw != KW_NONE) ? KIND_KEYWORD : KIND_VARIABLE;
          p_res.kw   = kw;
          run_idle   = 1'b1;
        end else begin
          if (cnt_q < LEN_W'(KW_CHARS)) begin
            prefix_d = {prefix_q[PREFIX_W-9:0], fb};
          end
          cnt_d = cnt_inc;
        end
      end
      MODE_STRING: begin
        if (b == CH_QUOTE) begin
          p_vld      = 1'b1;
          p_res.kind = KIND_STRING;
          mode_d     = MODE_IDLE;
        end else if (b == CH_CR || b == CH_NUL) begin
          p_vld      = 1'b1;
          p_res.kind = KIND_UNTERM;
          run_idle   = 1'b1;
        end else begin
          if (cnt_q == '0) begin
            fc_d = b;
          end
          cnt_d = cnt_inc;
        end
      end
      MODE_CR: begin
        p_vld    = 1'b1;
        p_res.fc = CH_CR;
        mode_d   = MODE_IDLE;
        if (b == CH_LF) begin
          p_res.kind = KIND_EOL;
          p_res.len  = LEN_W'(2);
        end else begin
          p_res.kind = KIND_INVALID;
          p_res.len  = LEN_W'(1);
          run_idle   = 1'b1;
        end
      end
      MODE_DONE: begin
      end
      default: begin
        run_idle = 1'b1;
      end
    endcase

    if (run_idle) begin
      mode_d = MODE_IDLE;
      if (b == CH_NUL) begin
        i_vld      = 1'b1;
        i_res.kind = KIND_END;
        i_res.len  = '0;
        i_res.fc   = CH_NUL;
        mode_d     = MODE_DONE;
      end else if (b == CH_SPACE || b == CH_TAB) begin
        // whitespace between tokens
      end else if (b == CH_CR) begin
        start_d = pos_q;
        mode_d  = MODE_CR;
      end else if (b == CH_LF) begin
        i_vld      = 1'b1;
        i_res.kind = KIND_EOL;
      end else if (is_op(b)) begin
        i_vld      = 1'b1;
        i_res.kind = KIND_SYMBOL;
      end else if (b == CH_QUOTE) begin
        start_d = pos_q;
        cnt_d   = '0;
        fc_d    = CH_NUL;
        mode_d  = MODE_STRING;
      end else if (b >= 8'h30 && b <= 8'h39) begin
        start_d = pos_q;
        cnt_d   = LEN_W'(1);
        fc_d    = b;
        mode_d  = MODE_NUMBER;
      end else if ((b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a)) begin
        start_d  = pos_q;
        cnt_d    = LEN_W'(1);
        fc_d     = b;
        prefix_d = {{(PREFIX_W-8){1'b0}}, b | CASE_BIT};
        mode_d   = MODE_WORD;
      end else begin
        i_vld      = 1'b1;
        i_res.kind = KIND_INVALID;
      end
    end

    pos_d = (pos_q < PosLimit) ? pos_q + POS_W'(1) : pos_q;
  end

  always_comb begin
    push_o.n       = fire_i ? (2'(p_vld) + 2'(i_vld)) : 2'd0;
    push_o.r0      = p_vld ? p_res : i_res;
    push_o.r0.last = !(p_vld && i_vld);
    push_o.r1      = i_res;
    push_o.r1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pos_q    <= '0;
      start_q  <= '0;
      cnt_q    <= '0;
      fc_q     <= '0;
      prefix_q <= '0;
    end else if (fire_i) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      start_q  <= start_d;
      cnt_q    <= cnt_d;
      fc_q     <= fc_d;
      prefix_q <= prefix_d;
    end
  end

`ifndef SYNTH
  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && mode_q == MODE_DONE) |-> push_o.n == 2'd0)
    else $error("token emitted after end of program");

  a_nul_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && byte_i == CH_NUL) |=> mode_q == MODE_DONE)
    else $error("NUL byte did not end the program");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.n == 2'd2 |-> (!push_o.r0.last && push_o.r1.kind != KIND_NUMBER &&
                          push_o.r1.kind != KIND_VARIABLE && push_o.r1.kind != KIND_KEYWORD))
    else $error("bad ordering of a two-token transfer");
`endif

endmodule

`default_nettype wire

// ===== hdl/btl_fifo.sv =====
// Result queue: takes up to two tokens per cycle, hands out one per transfer.
`default_nettype none

module btl_fifo (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire btl_pkg::btl_push_t      push_i,
  output logic                         room_o,
  output btl_pkg::btl_result_t         head_o,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i
);
  import btl_pkg::*;

  btl_result_t             q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0]   count_q, count_d;
  logic                    pop;

  assign out_valid_o = (count_q != '0);
  assign head_o      = q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  // room for a worst-case pair, regardless of a pop this cycle
  assign room_o      = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  assign wr_ptr_d = wr_ptr_q + FIFO_PTR_W'(push_i.n);
  assign rd_ptr_d = rd_ptr_q + FIFO_PTR_W'(pop);
  assign count_d  = count_q + FIFO_CNT_W'(push_i.n) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      q[wr_ptr_q + FIFO_PTR_W'(1)] <= push_i.r1;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n != 2'd0 |-> room_o)
    else $error("push without room for a pair");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q == FIFO_CNT_W'($past(count_q) + FIFO_CNT_W'($past(push_i.n))
                                    - FIFO_CNT_W'($past(pop))))
    else $error("queue fill count out of step with transfers");
`endif

endmodule

`default_nettype wire

// ===== hdl/basic_token_lexer.sv =====
// BASIC token lexer top level: input register, lexer core and result queue.
//
// Input channel: text_byte_i with in_valid_i / in_stall_o, one byte per
// transfer; byte 0 ends the program and produces the end token.
// Output channel: one token descriptor per transfer on out_valid_o /
// out_stall_i; last_of_run_o marks the final token caused by a byte.
// A byte is held in the input register and lexed once the result queue
// has room for two tokens; its tokens are written into the queue and can be taken from there.
// Numbers and words are reported when their delimiter byte is lexed.
// Throughput is one byte per cycle while the queue has room; a byte
// that closes a token and also forms another yields two tokens, and the
// single-token output port then sets the pace. The four-entry result queue
// lets the lexer run as long as it has room for two tokens, so in_stall_o
// rises only once the receiver has left three or more tokens waiting.
// Reset clears the lexer to its idle state at byte offset zero and empties
// the queue. After the end token all further bytes are taken and dropped
// until reset.
`default_nettype none

module basic_token_lexer #(
  parameter int unsigned ProgramBytes = btl_pkg::PROGRAM_BYTES,
  parameter int unsigned TokenMax     = btl_pkg::TOKEN_MAX
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    text_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [3:0]                         token_kind_o,
  output logic [3:0]                         keyword_code_o,
  output logic [btl_pkg::POS_W-1:0]          start_offset_o,
  output logic [btl_pkg::LEN_W-1:0]          token_length_o,
  output logic [7:0]                         first_char_o,
  output logic                               last_of_run_o
);
  import btl_pkg::*;

  logic         in_valid_q, in_valid_d;
  logic [7:0]   byte_q;
  logic         room, fire, load;
  btl_push_t    push;
  btl_result_t  head;

  assign fire       = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign load       = in_valid_i && !in_stall_o;
  assign in_valid_d = load ? 1'b1 : (fire ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= text_byte_i;
    end
  end

  btl_core #(
    .ProgramBytes (ProgramBytes),
    .TokenMax     (TokenMax)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (byte_q),
    .push_o (push)
  );

  btl_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .head_o      (head),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

  assign token_kind_o   = head.kind;
  assign keyword_code_o = head.kw;
  assign start_offset_o = head.start;
  assign token_length_o = head.len;
  assign first_char_o   = head.fc;
  assign last_of_run_o  = head.last;

endmodule

`default_nettype wire

// ===== dv/basic_token_lexer_tb.sv =====
// Self-checking testbench for the BASIC token lexer: directed table, random programs.
`timescale 1ns / 100ps

module basic_token_lexer_tb;
  import btl_pkg::*;

  localparam int unsigned POS_LIMIT = (PROGRAM_BYTES - 1 < 16383) ? PROGRAM_BYTES - 1 : 16383;
  localparam int unsigned LEN_LIMIT = (TOKEN_MAX < 127) ? TOKEN_MAX : 127;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned DIR_ROWS = 26;

  typedef struct {
    logic [7:0]       b;
    bit               typed;
    btl_kind_e        kind;
    logic [POS_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic [7:0]       fc;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [7:0]          text_byte_i = 8'h00;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [3:0]          token_kind_o;
  logic [3:0]          keyword_code_o;
  logic [POS_W-1:0]    start_offset_o;
  logic [LEN_W-1:0]    token_length_o;
  logic [7:0]          first_char_o;
  logic                last_of_run_o;

  // lexer prediction state
  btl_mode_e           lx_mode = MODE_IDLE;
  logic [POS_W-1:0]    lx_pos = '0;
  logic [POS_W-1:0]    lx_start = '0;
  logic [LEN_W-1:0]    lx_len = '0;
  logic [7:0]          lx_fc = '0;
  logic [PREFIX_W-1:0] lx_prefix = '0;
  btl_result_t         step_tok [2];
  int                  step_n;

  btl_result_t         expected_tokens [$];
  dir_row_t            dir_table [DIR_ROWS];
  string               op_chars = "+-*^/%=;(),><";
  int unsigned         mismatches = 0;
  int unsigned         bytes_sent = 0;
  int unsigned         tokens_seen = 0;
  int unsigned         long_holds = 0;
  bit [8:0]            kinds_seen = '0;
  bit                  send_calm = 1'b0;
  bit                  recv_calm = 1'b0;

  basic_token_lexer i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_byte_i    (text_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .keyword_code_o (keyword_code_o),
    .start_offset_o (start_offset_o),
    .token_length_o (token_length_o),
    .first_char_o   (first_char_o),
    .last_of_run_o  (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d tokens still pending", CYCLE_LIMIT,
             expected_tokens.size());
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- helpers

  function automatic bit is_op_byte(logic [7:0] b);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < op_chars.len(); i++) begin
      if (b == 8'(op_chars[i])) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic bit is_letter(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a);
  endfunction

  function automatic bit is_delim(logic [7:0] b);
    return b == CH_NUL || b == CH_TAB || b == CH_LF || b == CH_CR || b == CH_SPACE ||
           is_op_byte(b);
  endfunction

  function automatic bit starts_token(logic [7:0] b);
    return is_delim(b) || b == CH_QUOTE || is_digit(b) || is_letter(b);
  endfunction

  function automatic string kw_name(int k);
    case (k)
      0:       return "print";
      1:       return "input";
      2:       return "if";
      3:       return "then";
      4:       return "goto";
      5:       return "for";
      6:       return "next";
      7:       return "to";
      8:       return "gosub";
      9:       return "return";
      10:      return "end";
      default: return "rem";
    endcase
  endfunction

  function automatic logic [3:0] match_keyword();
    logic [PREFIX_W-1:0] name_bits;
    string               name;
    logic [3:0]          code;
    code = KW_NONE;
    if (lx_len <= KW_CHARS) begin
      for (int k = 0; k < KW_NUM; k++) begin
        name = kw_name(k);
        name_bits = '0;
        for (int i = 0; i < name.len(); i++) name_bits = {name_bits[PREFIX_W-9:0], 8'(name[i])};
        if (name.len() == lx_len && name_bits == lx_prefix) code = 4'(k + 1);
      end
    end
    return code;
  endfunction

  function automatic logic [LEN_W-1:0] len_inc(logic [LEN_W-1:0] l);
    return (l < LEN_LIMIT) ? l + 1'b1 : l;
  endfunction

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'($urandom_range(48, 57));
  endfunction

  // -------------------------------------------------------------- predictor

  task automatic emit_tok(input btl_kind_e k, input logic [3:0] code,
                          input logic [POS_W-1:0] s, input logic [LEN_W-1:0] l,
                          input logic [7:0] c);
    if (step_n < 2) begin
      step_tok[step_n] = '{kind: k, kw: code, start: s, len: l, fc: c, last: 1'b0};
      step_n++;
    end
  endtask

  // a byte seen between tokens
  task automatic lex_fresh(input logic [7:0] b, input logic [POS_W-1:0] p);
    if (b == CH_NUL) begin
      emit_tok(KIND_END, KW_NONE, p, 7'd0, 8'h00);
      lx_mode = MODE_DONE;
    end else if (b == CH_SPACE || b == CH_TAB) begin
      // whitespace is skipped
    end else if (b == CH_CR) begin
      lx_start = p;
      lx_mode = MODE_CR;
    end else if (b == CH_LF) begin
      emit_tok(KIND_EOL, KW_NONE, p, 7'd1, CH_LF);
    end else if (is_op_byte(b)) begin
      emit_tok(KIND_SYMBOL, KW_NONE, p, 7'd1, b);
    end else if (b == CH_QUOTE) begin
      lx_start = p;
      lx_len = '0;
      lx_fc = '0;
      lx_mode = MODE_STRING;
    end else if (is_digit(b)) begin
      lx_start = p;
      lx_len = 7'd1;
      lx_fc = b;
      lx_mode = MODE_NUMBER;
    end else if (is_letter(b)) begin
      lx_start = p;
      lx_len = 7'd1;
      lx_fc = b;
      lx_prefix = {40'd0, b | CASE_BIT};
      lx_mode = MODE_WORD;
    end else begin
      emit_tok(KIND_INVALID, KW_NONE, p, 7'd1, b);
    end
  endtask

  task automatic lex_byte(input logic [7:0] b);
    logic [POS_W-1:0] p;
    logic [3:0]       code;
    logic [7:0]       fb;
    step_n = 0;
    if (lx_mode == MODE_DONE) return;
    p = lx_pos;
    case (lx_mode)
      MODE_NUMBER: begin
        if (is_delim(b)) begin
          emit_tok(KIND_NUMBER, KW_NONE, lx_start, lx_len, lx_fc);
          lx_mode = MODE_IDLE;
          lex_fresh(b, p);
        end else begin
          lx_len = len_inc(lx_len);
        end
      end
      MODE_WORD: begin
        if (is_delim(b)) begin
          code = match_keyword();
          if (code != KW_NONE) emit_tok(KIND_KEYWORD, code, lx_start, lx_len, lx_fc);
          else emit_tok(KIND_VARIABLE, KW_NONE, lx_start, lx_len, lx_fc);
          lx_mode = MODE_IDLE;
          lex_fresh(b, p);
        end else begin
          fb = (b >= 8'h41 && b <= 8'h5a) ? (b | CASE_BIT) : b;
          if (lx_len < KW_CHARS) lx_prefix = {lx_prefix[PREFIX_W-9:0], fb};
          lx_len = len_inc(lx_len);
        end
      end
      MODE_STRING: begin
        if (b == CH_QUOTE) begin
          emit_tok(KIND_STRING, KW_NONE, lx_start, lx_len, lx_fc);
          lx_mode = MODE_IDLE;
        end else if (b == CH_CR || b == CH_NUL) begin
          emit_tok(KIND_UNTERM, KW_NONE, lx_start, lx_len, lx_fc);
          lx_mode = MODE_IDLE;
          lex_fresh(b, p);
        end else begin
          if (lx_len == 0) lx_fc = b;
          lx_len = len_inc(lx_len);
        end
      end
      MODE_CR: begin
        lx_mode = MODE_IDLE;
        if (b == CH_LF) begin
          emit_tok(KIND_EOL, KW_NONE, lx_start, 7'd2, CH_CR);
        end else begin
          emit_tok(KIND_INVALID, KW_NONE, lx_start, 7'd1, CH_CR);
          lex_fresh(b, p);
        end
      end
      default: begin
        lx_mode = MODE_IDLE;
        lex_fresh(b, p);
      end
    endcase
    if (lx_pos < POS_LIMIT) lx_pos = lx_pos + 1'b1;
    if (step_n > 0) step_tok[step_n-1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------- sender

  task automatic send_byte(input logic [7:0] b, input bit typed, input btl_result_t typed_tok,
                           input bit burst);
    int gap;
    gap = (burst || send_calm) ? 0 : $urandom_range(0, 18);
    if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    text_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    lex_byte(b);
    if (typed) begin
      expected_tokens = {expected_tokens, typed_tok};
    end else begin
      for (int i = 0; i < step_n; i++) expected_tokens = {expected_tokens, step_tok[i]};
    end
    bytes_sent++;
  endtask

  // one program line: mostly well-formed statements, some noise
  task automatic send_line();
    logic [7:0] line_q [$];
    logic [7:0] c;
    int         n;
    string      name;
    line_q = {};
    if ($urandom_range(0, 1)) begin
      repeat ($urandom_range(1, 4)) line_q = {line_q, rand_digit()};
      line_q = {line_q, CH_SPACE};
    end
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          name = kw_name($urandom_range(0, KW_NUM - 1));
          for (int i = 0; i < name.len(); i++) begin
            c = 8'(name[i]);
            if ($urandom_range(0, 1)) c = c & ~CASE_BIT;
            line_q = {line_q, c};
          end
          // keyword with a tail is a plain variable
          if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) line_q = {line_q, rand_letter()};
        end
        2: begin
          n = ($urandom_range(0, 15) == 0) ? $urandom_range(75, 90) : $urandom_range(1, 8);
          line_q = {line_q, rand_letter()};
          repeat (n - 1) begin
            case ($urandom_range(0, 9))
              0:       line_q = {line_q, 8'h24};
              1, 2:    line_q = {line_q, rand_digit()};
              default: line_q = {line_q, rand_letter()};
            endcase
          end
        end
        3: begin
          n = ($urandom_range(0, 15) == 0) ? $urandom_range(75, 90) : $urandom_range(1, 6);
          line_q = {line_q, rand_digit()};
          repeat (n - 1) line_q = {line_q, (($urandom_range(0, 9) == 0) ? 8'h2e : rand_digit())};
        end
        4: begin
          n = ($urandom_range(0, 15) == 0) ? $urandom_range(78, 90) : $urandom_range(0, 10);
          line_q = {line_q, CH_QUOTE};
          repeat (n) begin
            case ($urandom_range(0, 11))
              0: line_q = {line_q, CH_LF};
              1: line_q = {line_q, 8'($urandom_range(128, 255))};
              default: begin
                do c = 8'($urandom_range(32, 126)); while (c == CH_QUOTE);
                line_q = {line_q, c};
              end
            endcase
          end
          if ($urandom_range(0, 7) != 0) line_q = {line_q, CH_QUOTE};
        end
        5, 6: line_q = {line_q, 8'(op_chars[$urandom_range(0, 12)])};
        7: begin
          do c = 8'($urandom_range(1, 255)); while (starts_token(c));
          line_q = {line_q, c};
        end
        8: line_q = {line_q, 8'($urandom_range(1, 255))};
        default: line_q = {line_q, ($urandom_range(0, 1) ? CH_CR : CH_LF)};
      endcase
      case ($urandom_range(0, 3))
        0: ;
        1: line_q = {line_q, CH_SPACE};
        2: line_q = {line_q, CH_TAB};
        default: begin
          line_q = {line_q, CH_SPACE};
          line_q = {line_q, CH_SPACE};
        end
      endcase
    end
    n = $urandom_range(0, 9);
    if (n < 6) begin
      line_q = {line_q, CH_CR};
      line_q = {line_q, CH_LF};
    end else if (n < 9) begin
      line_q = {line_q, CH_LF};
    end else begin
      line_q = {line_q, CH_CR};
    end
    foreach (line_q[i]) send_byte(line_q[i], 1'b0, '0, 1'b0);
  endtask

  // -------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at token %0d: %s", tokens_seen, msg);
    mismatches++;
  endtask

  task automatic check_field(input string field, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", field, got, want));
  endtask

  initial begin : token_sink
    int          hold;
    btl_result_t want;
    wait (rst_ni === 1'b1);
    forever begin
      hold = recv_calm ? 0 : $urandom_range(0, 18);
      if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
      // long hold-off so the result queue fills and the input backs up
      if ((tokens_seen == 150 && long_holds == 0) || (tokens_seen == 600 && long_holds == 1)) begin
        hold = LONG_HOLD;
        long_holds++;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (token_kind_o <= KIND_UNTERM) kinds_seen[token_kind_o] = 1'b1;
      if (expected_tokens.size() == 0) begin
        report_mismatch($sformatf("unexpected token kind %0d at offset %0d", token_kind_o,
                                  start_offset_o));
      end else begin
        want = expected_tokens.pop_front();
        check_field("kind", 16'(token_kind_o), 16'(want.kind));
        check_field("keyword", 16'(keyword_code_o), 16'(want.kw));
        check_field("start", 16'(start_offset_o), 16'(want.start));
        check_field("length", 16'(token_length_o), 16'(want.len));
        check_field("first_char", 16'(first_char_o), 16'(want.fc));
        check_field("last_of_run", 16'(last_of_run_o), 16'(want.last));
      end
      tokens_seen++;
    end
  end

  // ------------------------------------------------------------------ main

  initial begin : main_seq
    btl_result_t typed_tok;
    dir_table = '{
      '{8'h2b,    1'b1, KIND_SYMBOL,  14'd0,  7'd1, 8'h2b},  // '+' right after reset
      '{8'h01,    1'b1, KIND_INVALID, 14'd1,  7'd1, 8'h01},  // stray character
      '{8'hff,    1'b1, KIND_INVALID, 14'd2,  7'd1, 8'hff},
      '{CH_CR,    1'b0, KIND_SYMBOL,  14'd0,  7'd0, 8'h00},  // lone CR ...
      '{8'h78,    1'b0, KIND_SYMBOL,  14'd0,  7'd0, 8'h00},  // ... closed by 'x'
      '{CH_SPACE, 1'b0, KIND_SYMBOL,  14'd0,  7'd0, 8'h00},
      '{8'h31,    1'b0, KIND_SYMBOL,  14'd0,  7'd0, 8'h00},
      '{8'h32,    1'b0, KIND_SYMBOL,  14'd0,  7'd0, 8'h00},
      '{8'h3b,    1'b0, KIND_SYMBOL,  14'd0,  7'd0, 8'h00},  // number and symbol at once
      '{8'h69,    1'b0, KIND_SYMBOL,  14'd0,  7'd0, 8'h00},
      '{8'h46,    1'b0, KIND_SYMBOL,  14'd0,  7'd0, 8'h00},
      '{CH_TAB,   1'b0, KIND_SYMBOL,  14'd0,  7'd0, 8'h00},
      '{CH_LF,    1'b1, KIND_EOL,     14'd12, 7'd1, CH_LF},
      '{CH_QUOTE, 1'b0, KIND_SYMBOL,  14'd0,  7'd0, 8'h00},  // empty string
      '{CH_QUOTE, 1'b0, KIND_SYMBOL,  14'd0,  7'd0, 8'h00},
      '{CH_QUOTE, 1'b0, KIND_SYMBOL,  14'd0,  7'd0, 8'h00},  // string cut by CR
      '{8'h71,    1'b0, KIND_SYMBOL,  14'd0,  7'd0, 8'h00},
      '{CH_CR,    1'b0, KIND_SYMBOL,  14'd0,  7'd0, 8'h00},
      '{CH_LF,    1'b0, KIND_SYMBOL,  14'd0,  7'd0, 8'h00},
      '{8'h39,    1'b0, KIND_SYMBOL,  14'd0,  7'd0, 8'h00},
      '{8'h28,    1'b0, KIND_SYMBOL,  14'd0,  7'd0, 8'h00},
      '{8'h7f,    1'b1, KIND_INVALID, 14'd21, 7'd1, 8'h7f},
      '{8'h72,    1'b0, KIND_SYMBOL,  14'd0,  7'd0, 8'h00},
      '{8'h45,    1'b0, KIND_SYMBOL,  14'd0,  7'd0, 8'h00},
      '{8'h6d,    1'b0, KIND_SYMBOL,  14'd0,  7'd0, 8'h00},
      '{8'h3d,    1'b0, KIND_SYMBOL,  14'd0,  7'd0, 8'h00}
    };
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i]) begin
      typed_tok = '{kind: dir_table[i].kind, kw: KW_NONE, start: dir_table[i].start,
                    len: dir_table[i].len, fc: dir_table[i].fc, last: 1'b1};
      send_byte(dir_table[i].b, dir_table[i].typed, typed_tok, 1'b0);
    end

    while (bytes_sent < 800) send_line();
    // blanks with no idle cycles between transfers
    repeat (200) send_byte(CH_SPACE, 1'b0, '0, 1'b1);
    while (bytes_sent < 1600) send_line();

    // string cut by end of program, then bytes that must be dropped
    send_byte(CH_QUOTE, 1'b0, '0, 1'b0);
    send_byte(8'h61, 1'b0, '0, 1'b0);
    send_byte(CH_NUL, 1'b0, '0, 1'b0);
    send_byte(8'h41, 1'b0, '0, 1'b0);
    send_byte(8'h2b, 1'b0, '0, 1'b0);
    send_byte(CH_NUL, 1'b0, '0, 1'b0);
    in_valid_i <= 1'b0;

    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d text bytes and %0d tokens, including long input back-pressure",
             bytes_sent, tokens_seen);
    $display("token kinds observed (bit per kind, unterminated..symbol): %b, final offset %0d",
             kinds_seen, lx_pos);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/btl_pkg.sv
hdl/btl_core.sv
hdl/btl_fifo.sv
hdl/basic_token_lexer.sv
dv/basic_token_lexer_tb.sv
